### src/bcd_clock_field_editor_defines.svh
// Assertion macros for the BCD clock field editor.
// Used by the top level; no other dependencies.
`ifndef BCD_CLOCK_FIELD_EDITOR_DEFINES_SVH
`define BCD_CLOCK_FIELD_EDITOR_DEFINES_SVH
`ifndef SYNTH
`define BCE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define BCE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BCE_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define BCE_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### src/bce_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes, field limits and BCD helper functions of the BCD clock field editor.
// No dependencies.
package bce_pkg;

   localparam int unsigned SEC_W   = 7;
   localparam int unsigned MIN_W   = 7;
   localparam int unsigned HOUR_W  = 6;
   localparam int unsigned DAY_W   = 6;
   localparam int unsigned MONTH_W = 5;
   localparam int unsigned YEAR_W  = 8;
   localparam int unsigned MODE_W  = 3;
   localparam int unsigned ADDR_W  = 8;

   typedef enum logic [1:0] {
      OP_MODE = 2'd0,
      OP_UP   = 2'd1,
      OP_DOWN = 2'd2,
      OP_LOAD = 2'd3
   } opcode_type;

   localparam logic [MODE_W-1:0] MODE_NONE  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SEC   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MIN   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_HOUR  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DAY   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_MONTH = 3'd5;
   localparam logic [MODE_W-1:0] MODE_YEAR  = 3'd6;

   localparam logic [7:0] SEC_LOW    = 8'h00;
   localparam logic [7:0] SEC_HIGH   = 8'h59;
   localparam logic [7:0] MIN_LOW    = 8'h00;
   localparam logic [7:0] MIN_HIGH   = 8'h59;
   localparam logic [7:0] HOUR_LOW   = 8'h00;
   localparam logic [7:0] HOUR_HIGH  = 8'h23;
   localparam logic [7:0] DAY_LOW    = 8'h01;
   localparam logic [7:0] DAY_HIGH   = 8'h31;
   localparam logic [7:0] MONTH_LOW  = 8'h01;
   localparam logic [7:0] MONTH_HIGH = 8'h12;
   localparam logic [7:0] YEAR_LOW   = 8'h00;
   localparam logic [7:0] YEAR_HIGH  = 8'h99;

   localparam logic [3:0] NIBBLE_UP_FIX   = 4'ha;
   localparam logic [3:0] NIBBLE_DOWN_FIX = 4'hf;
   localparam logic [7:0] BCD_ADJUST      = 8'h06;

   typedef struct packed {
      opcode_type          opcode;
      logic [SEC_W-1:0]    load_seconds;
      logic [MIN_W-1:0]    load_minutes;
      logic [HOUR_W-1:0]   load_hours;
      logic [DAY_W-1:0]    load_day;
      logic [MONTH_W-1:0]  load_month;
      logic [YEAR_W-1:0]   load_year;
   } req_item_type;

   typedef struct packed {
      logic [MODE_W-1:0]   edit_mode;
      logic [SEC_W-1:0]    seconds_bcd;
      logic [MIN_W-1:0]    minutes_bcd;
      logic [HOUR_W-1:0]   hours_bcd;
      logic [DAY_W-1:0]    day_bcd;
      logic [MONTH_W-1:0]  month_bcd;
      logic [YEAR_W-1:0]   year_bcd;
      logic                store_strobe;
      logic [ADDR_W-1:0]   cursor_addr;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      req_item_type item;
   } in_stage_type;

   function automatic logic [7:0] bcd_step(input logic up, input logic [7:0] value,
                                           input logic [7:0] low, input logic [7:0] high);
      logic [7:0] r;
      if (up) begin
         if (value >= high) begin
            r = low;
         end else begin
            r = value + 8'd1;
            if (r[3:0] == NIBBLE_UP_FIX) begin
               r = r + BCD_ADJUST;
            end
         end
      end else begin
         if (value <= low || value > high) begin
            r = high;
         end else begin
            r = value - 8'd1;
            if (r[3:0] == NIBBLE_DOWN_FIX) begin
               r = r - BCD_ADJUST;
            end
         end
      end
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] cursor_of(input logic [MODE_W-1:0] mode);
      logic [ADDR_W-1:0] a;
      unique case (mode)
         MODE_SEC:   a = 8'hd3;
         MODE_MIN:   a = 8'hd0;
         MODE_HOUR:  a = 8'hcd;
         MODE_DAY:   a = 8'h8d;
         MODE_MONTH: a = 8'h90;
         MODE_YEAR:  a = 8'h93;
         default:    a = 8'h00;
      endcase
      return a;
   endfunction

endpackage

### src/bce_req_if.sv
`timescale 1ns / 1ps
// Request channel interface of the BCD clock field editor: valid, ready and key or load payload.
// Depends on bce_pkg.
interface bce_req_if
   import bce_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic [SEC_W-1:0]   load_seconds;
   logic [MIN_W-1:0]   load_minutes;
   logic [HOUR_W-1:0]  load_hours;
   logic [DAY_W-1:0]   load_day;
   logic [MONTH_W-1:0] load_month;
   logic [YEAR_W-1:0]  load_year;

   modport source (
      output valid, opcode, load_seconds, load_minutes, load_hours, load_day,
             load_month, load_year,
      input  ready
   );
   modport sink (
      input  valid, opcode, load_seconds, load_minutes, load_hours, load_day,
             load_month, load_year,
      output ready
   );
endinterface

### src/bce_rsp_if.sv
`timescale 1ns / 1ps
// Response channel interface of the BCD clock field editor: valid, ready and field payload.
// Depends on bce_pkg.
interface bce_rsp_if
   import bce_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  edit_mode;
   logic [SEC_W-1:0]   seconds_bcd;
   logic [MIN_W-1:0]   minutes_bcd;
   logic [HOUR_W-1:0]  hours_bcd;
   logic [DAY_W-1:0]   day_bcd;
   logic [MONTH_W-1:0] month_bcd;
   logic [YEAR_W-1:0]  year_bcd;
   logic               store_strobe;
   logic [ADDR_W-1:0]  cursor_addr;

   modport source (
      output valid, edit_mode, seconds_bcd, minutes_bcd, hours_bcd, day_bcd,
             month_bcd, year_bcd, store_strobe, cursor_addr,
      input  ready
   );
   modport sink (
      input  valid, edit_mode, seconds_bcd, minutes_bcd, hours_bcd, day_bcd,
             month_bcd, year_bcd, store_strobe, cursor_addr,
      output ready
   );
endinterface

### src/bce_in_reg.sv
`timescale 1ns / 1ps
// Input register of the BCD clock field editor; holds one request transaction.
// Depends on bce_pkg.
module bce_in_reg
   import bce_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  req_item_type req_item,
   output logic         req_ready,
   input  logic         take,
   output in_stage_type stage
);
   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         accept;

   assign req_ready = !valid_ff || take;
   assign accept    = req_valid && req_ready;
   assign valid_in  = accept || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;
endmodule

### src/bce_core.sv
`timescale 1ns / 1ps
// Mode and BCD field state of the editor with the per-transaction update logic.
// Depends on bce_pkg.
module bce_core
   import bce_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   output rsp_item_type result
);
   logic [MODE_W-1:0]  mode_ff,  mode_in;
   logic [SEC_W-1:0]   sec_ff,   sec_in;
   logic [MIN_W-1:0]   min_ff,   min_in;
   logic [HOUR_W-1:0]  hour_ff,  hour_in;
   logic [DAY_W-1:0]   day_ff,   day_in;
   logic [MONTH_W-1:0] month_ff, month_in;
   logic [YEAR_W-1:0]  year_ff,  year_in;
   logic               strobe;
   logic               up;
   logic [7:0]         stepped;

   always_comb begin
      mode_in  = mode_ff;
      sec_in   = sec_ff;
      min_in   = min_ff;
      hour_in  = hour_ff;
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      strobe   = 1'b0;
      up       = (item.opcode == OP_UP);
      stepped  = 8'h00;
      unique case (item.opcode)
         OP_MODE: begin
            mode_in = (mode_ff < MODE_YEAR) ? mode_ff + 3'd1 : MODE_NONE;
         end
         OP_LOAD: begin
            sec_in   = item.load_seconds;
            min_in   = item.load_minutes;
            hour_in  = item.load_hours;
            day_in   = item.load_day;
            month_in = item.load_month;
            year_in  = item.load_year;
         end
         OP_UP, OP_DOWN: begin
            unique case (mode_ff)
               MODE_SEC: begin
                  stepped = bcd_step(up, {1'b0, sec_ff}, SEC_LOW, SEC_HIGH);
                  sec_in  = stepped[SEC_W-1:0];
                  strobe  = 1'b1;
               end
               MODE_MIN: begin
                  stepped = bcd_step(up, {1'b0, min_ff}, MIN_LOW, MIN_HIGH);
                  min_in  = stepped[MIN_W-1:0];
                  strobe  = 1'b1;
               end
               MODE_HOUR: begin
                  stepped = bcd_step(up, {2'b00, hour_ff}, HOUR_LOW, HOUR_HIGH);
                  hour_in = stepped[HOUR_W-1:0];
                  strobe  = 1'b1;
               end
               MODE_DAY: begin
                  stepped = bcd_step(up, {2'b00, day_ff}, DAY_LOW, DAY_HIGH);
                  day_in  = stepped[DAY_W-1:0];
                  strobe  = 1'b1;
               end
               MODE_MONTH: begin
                  stepped  = bcd_step(up, {3'b000, month_ff}, MONTH_LOW, MONTH_HIGH);
                  month_in = stepped[MONTH_W-1:0];
                  strobe   = 1'b1;
               end
               MODE_YEAR: begin
                  stepped = bcd_step(up, year_ff, YEAR_LOW, YEAR_HIGH);
                  year_in = stepped;
                  strobe  = 1'b1;
               end
               default: begin
                  strobe = 1'b0;
               end
            endcase
         end
         default: begin
            strobe = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NONE;
         sec_ff   <= SEC_LOW[SEC_W-1:0];
         min_ff   <= MIN_LOW[MIN_W-1:0];
         hour_ff  <= HOUR_LOW[HOUR_W-1:0];
         day_ff   <= DAY_LOW[DAY_W-1:0];
         month_ff <= MONTH_LOW[MONTH_W-1:0];
         year_ff  <= YEAR_LOW;
      end else if (step) begin
         mode_ff  <= mode_in;
         sec_ff   <= sec_in;
         min_ff   <= min_in;
         hour_ff  <= hour_in;
         day_ff   <= day_in;
         month_ff <= month_in;
         year_ff  <= year_in;
      end
   end

   assign result.edit_mode    = mode_in;
   assign result.seconds_bcd  = sec_in;
   assign result.minutes_bcd  = min_in;
   assign result.hours_bcd    = hour_in;
   assign result.day_bcd      = day_in;
   assign result.month_bcd    = month_in;
   assign result.year_bcd     = year_in;
   assign result.store_strobe = strobe;
   assign result.cursor_addr  = cursor_of(mode_in);
endmodule

### src/bcd_clock_field_editor.sv
`timescale 1ns / 1ps
// BCD clock field editor: an accepted request passes through the input register and the response register,
// with one pass of update logic between them, before the response goes valid.
// Throughput is one transaction per cycle while the response side is ready.
// Synchronous active-high reset clears both valid flags, sets the mode to none,
// the day and month to 01 and the other fields to 00.
module bcd_clock_field_editor
   import bce_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   bce_req_if.sink   req_if,
   bce_rsp_if.source rsp_if
);
`include "bcd_clock_field_editor_defines.svh"

   req_item_type req_item;
   in_stage_type stage;
   rsp_item_type result;
   rsp_item_type rsp_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic         rsp_free;
   logic         advance;

   assign req_item.opcode       = opcode_type'(req_if.opcode);
   assign req_item.load_seconds = req_if.load_seconds;
   assign req_item.load_minutes = req_if.load_minutes;
   assign req_item.load_hours   = req_if.load_hours;
   assign req_item.load_day     = req_if.load_day;
   assign req_item.load_month   = req_if.load_month;
   assign req_item.load_year    = req_if.load_year;

   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;
   assign advance      = stage.valid && rsp_free;
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_if.ready);

   bce_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_item  (req_item),
      .req_ready (req_if.ready),
      .take      (advance),
      .stage     (stage)
   );

   bce_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (stage.item),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.edit_mode    = rsp_ff.edit_mode;
   assign rsp_if.seconds_bcd  = rsp_ff.seconds_bcd;
   assign rsp_if.minutes_bcd  = rsp_ff.minutes_bcd;
   assign rsp_if.hours_bcd    = rsp_ff.hours_bcd;
   assign rsp_if.day_bcd      = rsp_ff.day_bcd;
   assign rsp_if.month_bcd    = rsp_ff.month_bcd;
   assign rsp_if.year_bcd     = rsp_ff.year_bcd;
   assign rsp_if.store_strobe = rsp_ff.store_strobe;
   assign rsp_if.cursor_addr  = rsp_ff.cursor_addr;

   `BCE_ASSERT_NEXT(a_edit_strobe, clock, reset, advance && (stage.item.opcode == OP_UP || stage.item.opcode == OP_DOWN), rsp_ff.store_strobe == (rsp_ff.edit_mode != MODE_NONE), "Edit strobe does not match the edit mode.")
   `BCE_ASSERT_NEXT(a_no_strobe, clock, reset, advance && (stage.item.opcode == OP_MODE || stage.item.opcode == OP_LOAD), !rsp_ff.store_strobe, "Strobe raised for a mode key or a load.")
   `BCE_ASSERT_NOW(a_cursor_mode, clock, reset, rsp_valid_ff, (rsp_ff.edit_mode == MODE_NONE) == (rsp_ff.cursor_addr == 8'h00), "Cursor address disagrees with the edit mode.")
endmodule

### verif/bcd_clock_field_editor_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bcd_clock_field_editor: directed and random key and load traffic
// with random stalls on both channels, checked against a field-level prediction.
// Depends on bce_pkg, bce_req_if, bce_rsp_if and the bcd_clock_field_editor RTL.
module bcd_clock_field_editor_tb;
   import bce_pkg::*;

   class field_edit_ledger;
      rsp_item_type      expected_readouts[$];
      logic [MODE_W-1:0] mode;
      logic [7:0]        field_value[6];
      logic [7:0]        low_limit[6];
      logic [7:0]        high_limit[6];
      logic [ADDR_W-1:0] cursor_by_mode[7];
      int unsigned       error_count;

      function new();
         mode           = MODE_NONE;
         field_value    = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00};
         low_limit      = '{SEC_LOW, MIN_LOW, HOUR_LOW, DAY_LOW, MONTH_LOW, YEAR_LOW};
         high_limit     = '{SEC_HIGH, MIN_HIGH, HOUR_HIGH, DAY_HIGH, MONTH_HIGH, YEAR_HIGH};
         cursor_by_mode = '{8'h00, 8'hd3, 8'hd0, 8'hcd, 8'h8d, 8'h90, 8'h93};
         error_count    = 0;
      endfunction

      function logic [7:0] bcd_increment(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
         logic [7:0] r;
         if (v >= hi) return lo;
         r = v + 8'd1;
         if (r[3:0] == NIBBLE_UP_FIX) r = r + BCD_ADJUST;
         return r;
      endfunction

      function logic [7:0] bcd_decrement(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
         logic [7:0] r;
         if (v <= lo || v > hi) return hi;
         r = v - 8'd1;
         if (r[3:0] == NIBBLE_DOWN_FIX) r = r - BCD_ADJUST;
         return r;
      endfunction

      function void note_keypress(req_item_type key);
         rsp_item_type readout;
         int unsigned  slot;
         logic         strobe;
         strobe = 1'b0;
         case (key.opcode)
            OP_MODE: begin
               mode = (mode < MODE_YEAR) ? mode + 3'd1 : MODE_NONE;
            end
            OP_LOAD: begin
               field_value[0] = {1'b0, key.load_seconds};
               field_value[1] = {1'b0, key.load_minutes};
               field_value[2] = {2'b00, key.load_hours};
               field_value[3] = {2'b00, key.load_day};
               field_value[4] = {3'b000, key.load_month};
               field_value[5] = key.load_year;
            end
            default: begin
               if (mode != MODE_NONE) begin
                  slot = mode - 1;
                  if (key.opcode == OP_UP) begin
                     field_value[slot] = bcd_increment(field_value[slot], low_limit[slot],
                                                       high_limit[slot]);
                  end else begin
                     field_value[slot] = bcd_decrement(field_value[slot], low_limit[slot],
                                                       high_limit[slot]);
                  end
                  strobe = 1'b1;
               end
            end
         endcase
         readout.edit_mode    = mode;
         readout.seconds_bcd  = field_value[0][SEC_W-1:0];
         readout.minutes_bcd  = field_value[1][MIN_W-1:0];
         readout.hours_bcd    = field_value[2][HOUR_W-1:0];
         readout.day_bcd      = field_value[3][DAY_W-1:0];
         readout.month_bcd    = field_value[4][MONTH_W-1:0];
         readout.year_bcd     = field_value[5];
         readout.store_strobe = strobe;
         readout.cursor_addr  = cursor_by_mode[mode];
         expected_readouts.push_back(readout);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned seen);
         if (want != seen) begin
            if (error_count < 10) begin
               $display("%0t: readout mismatch on %s: expected %0h, got %0h",
                        $realtime, name, want, seen);
            end
            error_count++;
         end
      endfunction

      function void check_readout(rsp_item_type seen);
         rsp_item_type want;
         if (expected_readouts.size() == 0) begin
            if (error_count < 10) begin
               $display("%0t: readout arrived with none expected", $realtime);
            end
            error_count++;
            return;
         end
         want = expected_readouts.pop_front();
         compare_field("edit_mode", want.edit_mode, seen.edit_mode);
         compare_field("seconds_bcd", want.seconds_bcd, seen.seconds_bcd);
         compare_field("minutes_bcd", want.minutes_bcd, seen.minutes_bcd);
         compare_field("hours_bcd", want.hours_bcd, seen.hours_bcd);
         compare_field("day_bcd", want.day_bcd, seen.day_bcd);
         compare_field("month_bcd", want.month_bcd, seen.month_bcd);
         compare_field("year_bcd", want.year_bcd, seen.year_bcd);
         compare_field("store_strobe", want.store_strobe, seen.store_strobe);
         compare_field("cursor_addr", want.cursor_addr, seen.cursor_addr);
      endfunction

      function int unsigned outstanding();
         return expected_readouts.size();
      endfunction
   endclass

   logic             clock;
   logic             reset;
   int unsigned      keys_sent;
   field_edit_ledger ledger;

   bce_req_if req_ch();
   bce_rsp_if rsp_ch();

   bcd_clock_field_editor dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("bcd_clock_field_editor_tb: done, errors");
      $finish;
   end

   function automatic int unsigned idle_gap(input bit quiet);
      int unsigned r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] to_bcd(input int unsigned v);
      return 8'(((v / 10) << 4) | (v % 10));
   endfunction

   function automatic req_item_type key_item(input opcode_type op);
      req_item_type k;
      logic [31:0]  bits_a;
      logic [31:0]  bits_b;
      bits_a         = $urandom;
      bits_b         = $urandom;
      k.opcode       = op;
      k.load_seconds = bits_a[6:0];
      k.load_minutes = bits_a[13:7];
      k.load_hours   = bits_a[19:14];
      k.load_day     = bits_a[25:20];
      k.load_month   = bits_a[30:26];
      k.load_year    = bits_b[7:0];
      return k;
   endfunction

   function automatic req_item_type load_item(input logic [SEC_W-1:0] s,
                                              input logic [MIN_W-1:0] m,
                                              input logic [HOUR_W-1:0] h,
                                              input logic [DAY_W-1:0] d,
                                              input logic [MONTH_W-1:0] mo,
                                              input logic [YEAR_W-1:0] y);
      req_item_type k;
      k.opcode       = OP_LOAD;
      k.load_seconds = s;
      k.load_minutes = m;
      k.load_hours   = h;
      k.load_day     = d;
      k.load_month   = mo;
      k.load_year    = y;
      return k;
   endfunction

   function automatic req_item_type bcd_load_item();
      return load_item(7'(to_bcd($urandom_range(0, 59))), 7'(to_bcd($urandom_range(0, 59))),
                       6'(to_bcd($urandom_range(0, 23))), 6'(to_bcd($urandom_range(1, 31))),
                       5'(to_bcd($urandom_range(1, 12))), to_bcd($urandom_range(0, 99)));
   endfunction

   task automatic send_keypress(input req_item_type key, input int unsigned gap);
      req_ch.valid        <= 1'b1;
      req_ch.opcode       <= key.opcode;
      req_ch.load_seconds <= key.load_seconds;
      req_ch.load_minutes <= key.load_minutes;
      req_ch.load_hours   <= key.load_hours;
      req_ch.load_day     <= key.load_day;
      req_ch.load_month   <= key.load_month;
      req_ch.load_year    <= key.load_year;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      ledger.note_keypress(key);
      keys_sent++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (ledger.outstanding() != 0);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         ledger.check_readout('{edit_mode: rsp_ch.edit_mode, seconds_bcd: rsp_ch.seconds_bcd,
                                minutes_bcd: rsp_ch.minutes_bcd, hours_bcd: rsp_ch.hours_bcd,
                                day_bcd: rsp_ch.day_bcd, month_bcd: rsp_ch.month_bcd,
                                year_bcd: rsp_ch.year_bcd, store_strobe: rsp_ch.store_strobe,
                                cursor_addr: rsp_ch.cursor_addr});
      end
   end

   initial begin
      int unsigned burst;
      int unsigned pause;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 10);
         rsp_ch.ready <= 1'b1;
         repeat (burst) @(posedge clock);
         pause = idle_gap(1'b0);
         if (pause > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
      end
   end

   initial begin
      req_item_type directed[$];
      opcode_type   heading;
      opcode_type   op;
      int unsigned  pick;
      int unsigned  presses;
      int unsigned  run;
      bit           quiet;

      ledger              = new();
      keys_sent           = 0;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.opcode       <= OP_MODE;
      req_ch.load_seconds <= '0;
      req_ch.load_minutes <= '0;
      req_ch.load_hours   <= '0;
      req_ch.load_day     <= '0;
      req_ch.load_month   <= '0;
      req_ch.load_year    <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Edits in mode none, extreme loads, wraps of all fields but the hours, then non-BCD digits.
      directed = '{key_item(OP_DOWN), key_item(OP_UP),
                   load_item(7'h00, 7'h00, 6'h00, 6'h00, 5'h00, 8'h00),
                   load_item(7'h7f, 7'h7f, 6'h3f, 6'h3f, 5'h1f, 8'hff),
                   key_item(OP_MODE), key_item(OP_UP), key_item(OP_DOWN),
                   load_item(7'h59, 7'h59, 6'h23, 6'h01, 5'h12, 8'h99),
                   key_item(OP_UP), key_item(OP_MODE), key_item(OP_UP),
                   key_item(OP_MODE), key_item(OP_DOWN),
                   key_item(OP_MODE), key_item(OP_DOWN), key_item(OP_UP),
                   key_item(OP_MODE), key_item(OP_UP), key_item(OP_DOWN),
                   key_item(OP_MODE), key_item(OP_UP), key_item(OP_DOWN),
                   key_item(OP_MODE),
                   load_item(7'h3c, 7'h4f, 6'h1a, 6'h2b, 5'h0e, 8'had),
                   key_item(OP_MODE), key_item(OP_UP)};
      foreach (directed[i]) send_keypress(directed[i], idle_gap(1'b0));
      drain_results();

      while (keys_sent < 1400) begin
         quiet = ($urandom_range(0, 4) == 0);
         pick  = $urandom_range(0, 99);
         if (pick < 70) begin
            presses = $urandom_range(0, 3);
            repeat (presses) send_keypress(key_item(OP_MODE), idle_gap(quiet));
            run     = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 110)
                                                  : $urandom_range(1, 12);
            heading = ($urandom_range(0, 1) == 0) ? OP_UP : OP_DOWN;
            repeat (run) begin
               op = heading;
               if ($urandom_range(0, 6) == 0) op = (heading == OP_UP) ? OP_DOWN : OP_UP;
               send_keypress(key_item(op), idle_gap(quiet));
            end
         end else if (pick < 85) begin
            send_keypress(bcd_load_item(), idle_gap(quiet));
         end else if (pick < 95) begin
            send_keypress(key_item(OP_LOAD), idle_gap(quiet));
         end else begin
            send_keypress(key_item(opcode_type'($urandom_range(0, 3))), idle_gap(quiet));
         end
         if ($urandom_range(0, 39) == 0) drain_results();
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (ledger.error_count == 0) begin
         $display("bcd_clock_field_editor_tb: done, clean");
      end else begin
         $display("bcd_clock_field_editor_tb: done, errors");
      end
      $finish;
   end

endmodule
